// ===== design/assert_macros.svh =====
// Shared assertion macros for the kerning pair table checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define KPTL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kerning table check failed");

// Check a property on every clock edge, reset included.
`define KPTL_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("kerning table reset check failed");

`endif

// ===== design/kptl_pkg.sv =====
package kptl_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int PTR_W       = ADDR_W + 1;

   // Fixed field widths
   localparam int COUNT_W = 11;
   localparam int SLOT_W  = 10;
   localparam int CHAR_W  = 16;
   localparam int ADJ_W   = 16;

   // Request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [SLOT_W-1:0]        entry_index;
      logic [CHAR_W-1:0]        first_char;
      logic [CHAR_W-1:0]        second_char;
      logic signed [ADJ_W-1:0]  entry_adjust;
   } kptl_req_type;

   typedef struct packed {
      logic                     found;
      logic signed [ADJ_W-1:0]  kern_adjust;
      logic [SLOT_W-1:0]        match_index;
   } kptl_rsp_type;

   typedef struct packed {
      logic [CHAR_W-1:0]        key1;
      logic [CHAR_W-1:0]        key2;
      logic signed [ADJ_W-1:0]  adj;
   } kptl_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_SCAN,
      ST_SCAN_CMP,
      ST_DONE
   } kptl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic wr;
      logic rd;
      logic rd_scan;
      logic srch_step;
      logic scan_next;
      logic hit;
      logic miss;
      logic rsp_load;
   } kptl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic srch_live;
      logic scan_live;
      logic key1_eq;
      logic key2_eq;
      logic rsp_free;
   } kptl_sts_type;

endpackage

// ===== design/kptl_ctrl.sv =====
module kptl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_stall,
   input  kptl_pkg::kptl_sts_type sts,
   output kptl_pkg::kptl_cmd_type cmd
);
   import kptl_pkg::*;

   kptl_state_type state_ff;
   kptl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == REQ_LOOKUP) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SRCH;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_SRCH: begin
            // issue a read at the midpoint, or move on to the group scan
            if (sts.srch_live) begin
               cmd.rd   = 1'b1;
               state_in = ST_SRCH_CMP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SRCH_CMP: begin
            cmd.srch_step = 1'b1;
            state_in      = ST_SRCH;
         end
         ST_SCAN: begin
            if (sts.scan_live) begin
               cmd.rd      = 1'b1;
               cmd.rd_scan = 1'b1;
               state_in    = ST_SCAN_CMP;
            end else begin
               cmd.miss = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_SCAN_CMP: begin
            // stop on a hit or on leaving the first-char group
            if (sts.key1_eq && sts.key2_eq) begin
               cmd.hit  = 1'b1;
               state_in = ST_DONE;
            end else if (sts.key1_eq) begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.miss = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/kptl_dp.sv =====
module kptl_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  kptl_pkg::kptl_req_type         req_data,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output kptl_pkg::kptl_rsp_type         rsp_data,
   input  logic                           csr_wr_en,
   input  logic [kptl_pkg::COUNT_W-1:0]   csr_wr_data,
   input  kptl_pkg::kptl_cmd_type         cmd,
   output kptl_pkg::kptl_sts_type         sts
);
   import kptl_pkg::*;

   kptl_entry_type mem [TABLE_DEPTH];
   kptl_entry_type rd_data_ff;
   kptl_entry_type wr_entry;

   logic [COUNT_W-1:0] pair_count_ff;
   logic [COUNT_W-1:0] pair_count_in;
   logic [PTR_W-1:0]   live_n;
   logic [PTR_W-1:0]   lo_ff, lo_in;
   logic [PTR_W-1:0]   hi_ff, hi_in;
   logic [PTR_W-1:0]   mid;
   logic [CHAR_W-1:0]  key1_ff, key1_in;
   logic [CHAR_W-1:0]  key2_ff, key2_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_ok;
   kptl_rsp_type       res_ff, res_in;
   kptl_rsp_type       rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Count register, clamped to the table depth
   always_comb begin
      pair_count_in = csr_wr_en ? csr_wr_data : pair_count_ff;
      if (32'(pair_count_ff) > TABLE_DEPTH) begin
         live_n = PTR_W'(TABLE_DEPTH);
      end else begin
         live_n = PTR_W'(pair_count_ff);
      end
   end

   // Search window and keys
   always_comb begin
      mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      key1_in = key1_ff;
      key2_in = key2_ff;
      if (cmd.start) begin
         lo_in   = '0;
         hi_in   = live_n;
         key1_in = req_data.first_char;
         key2_in = req_data.second_char;
      end else if (cmd.srch_step) begin
         if (rd_data_ff.key1 < key1_ff) begin
            lo_in = mid + PTR_W'(1);
         end else begin
            hi_in = mid;
         end
      end else if (cmd.scan_next) begin
         lo_in = lo_ff + PTR_W'(1);
      end
   end

   // Table ports
   always_comb begin
      rd_addr           = cmd.rd_scan ? lo_ff[ADDR_W-1:0] : mid[ADDR_W-1:0];
      wr_addr           = ADDR_W'(req_data.entry_index);
      wr_ok             = 32'(req_data.entry_index) < TABLE_DEPTH;
      wr_entry.key1     = req_data.first_char;
      wr_entry.key2     = req_data.second_char;
      wr_entry.adj      = req_data.entry_adjust;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr && wr_ok) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Result and output register
   always_comb begin
      res_in = res_ff;
      if (cmd.hit) begin
         res_in.found       = 1'b1;
         res_in.kern_adjust = rd_data_ff.adj;
         res_in.match_index = SLOT_W'(lo_ff);
      end else if (cmd.miss) begin
         res_in = '0;
      end
      rsp_data_in = cmd.rsp_load ? res_ff : rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      key1_ff     <= key1_in;
      key2_ff     <= key2_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_count_ff <= pair_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Status back to the controller
   always_comb begin
      sts.srch_live = lo_ff < hi_ff;
      sts.scan_live = lo_ff < live_n;
      sts.key1_eq   = rd_data_ff.key1 == key1_ff;
      sts.key2_eq   = rd_data_ff.key2 == key2_ff;
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/kern_pair_table_lookup.sv =====
// Channel    Direction  Handshake          Payload
// req        in         req_valid/stall    kptl_req_type (write or lookup)
// rsp        out        rsp_valid/stall    kptl_rsp_type (lookup only)
// csr        in         csr_wr_en          pair_count, 11 bits
//
// A write transaction gives no response and does not occupy the block.
// A lookup runs a lower-bound search on the first char, halving the window at
// each step, then scans the matching first-char group for the second char;
// each search step and each scanned entry needs a read of the single table read
// port, and the request side stalls until the lookup is done.
// Reset is synchronous: it clears the count and the response valid, not the table.
// A stalled response holds in the output register while the next request is taken.

module kern_pair_table_lookup (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  kptl_pkg::kptl_req_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output kptl_pkg::kptl_rsp_type         rsp_data,
   input  logic                           csr_wr_en,
   input  logic [kptl_pkg::COUNT_W-1:0]   csr_wr_data
);
   import kptl_pkg::*;

   kptl_cmd_type cmd;
   kptl_sts_type sts;

   kptl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kptl_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== design/kptl_checker.sv =====
`include "assert_macros.svh"

module kptl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input kptl_pkg::kptl_req_type         req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input kptl_pkg::kptl_rsp_type         rsp_data,
   input logic                           csr_wr_en,
   input logic [kptl_pkg::COUNT_W-1:0]   csr_wr_data
);
   import kptl_pkg::*;

   // No response comes out of reset
   `KPTL_ASSERT_ALWAYS(a_rst_no_rsp, reset |=> !rsp_valid)

   // A stalled response holds
   `KPTL_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // A miss reports zero adjustment and slot
   `KPTL_ASSERT(a_miss_zero, rsp_valid && !rsp_data.found |-> rsp_data.kern_adjust == 0 && rsp_data.match_index == 0)

   // A lookup occupies the block, a write does not
   `KPTL_ASSERT(a_lookup_busy, req_valid && !req_stall && req_data.req_type == REQ_LOOKUP |=> req_stall)
   `KPTL_ASSERT(a_write_free, req_valid && !req_stall && req_data.req_type == REQ_WRITE |=> !req_stall)

endmodule

bind kern_pair_table_lookup kptl_checker u_kptl_checker (.*);

// ===== tb/sv/tb_kern_pair_table_lookup.sv =====
`timescale 1ns / 100ps

module tb_kern_pair_table_lookup;
   import kptl_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEM_TARGET = 1900;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   kptl_req_type         req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   kptl_rsp_type         rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;

   // Expected lookup results and the table image they are computed from
   kptl_entry_type       kern_table [TABLE_DEPTH];
   logic [COUNT_W-1:0]   kern_pair_count = '0;
   kptl_rsp_type         kern_rsp_expected [$];

   // Stimulus side: pending transactions and the planned table contents
   kptl_req_type         pending_req [$];
   kptl_entry_type       plan_table [TABLE_DEPTH];
   bit                   plan_loaded [TABLE_DEPTH];
   int unsigned          items_queued = 0;
   bit                   calm = 1'b0;
   int unsigned          fail_count = 0;
   int unsigned          cycle_count = 0;

   kern_pair_table_lookup uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lower-bound search on the first char, then scan its group for the second char
   function automatic kptl_rsp_type predict_kern_lookup(input logic [CHAR_W-1:0] k1,
                                                        input logic [CHAR_W-1:0] k2);
      int unsigned  n;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      int unsigned  i;
      kptl_rsp_type r;
      n  = (kern_pair_count > TABLE_DEPTH) ? TABLE_DEPTH : kern_pair_count;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (kern_table[mid].key1 < k1) lo = mid + 1;
         else hi = mid;
      end
      r = '0;
      for (i = lo; i < n && kern_table[i].key1 == k1 && !r.found; i++) begin
         if (kern_table[i].key2 == k2) begin
            r.found       = 1'b1;
            r.kern_adjust = kern_table[i].adj;
            r.match_index = SLOT_W'(i);
         end
      end
      return r;
   endfunction

   // Drive request transactions and predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.req_type == REQ_WRITE) begin
               kern_table[req_data.entry_index] =
                  {req_data.first_char, req_data.second_char, req_data.entry_adjust};
            end else begin
               kern_rsp_expected.push_back(
                  predict_kern_lookup(req_data.first_char, req_data.second_char));
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_req.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
               req_data  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each response against the oldest prediction; stall at random
   always @(posedge clock) begin : rsp_monitor
      kptl_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (kern_rsp_expected.size() == 0) begin
               $error("unexpected response: found=%0d kern_adjust=%0d match_index=%0d",
                      rsp_data.found, rsp_data.kern_adjust, rsp_data.match_index);
               fail_count++;
            end else begin
               want = kern_rsp_expected.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.kern_adjust !== want.kern_adjust) begin
                  $error("kern_adjust: expected %0d, got %0d",
                         want.kern_adjust, rsp_data.kern_adjust);
                  fail_count++;
               end
               if (rsp_data.match_index !== want.match_index) begin
                  $error("match_index: expected %0d, got %0d",
                         want.match_index, rsp_data.match_index);
                  fail_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 13);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("kern_pair_table_lookup regression: fail");
         $finish;
      end
   end

   task automatic push_write(input int unsigned slot, input logic [CHAR_W-1:0] k1,
                             input logic [CHAR_W-1:0] k2, input logic [ADJ_W-1:0] adj);
      kptl_req_type t;
      t.req_type     = REQ_WRITE;
      t.entry_index  = SLOT_W'(slot);
      t.first_char   = k1;
      t.second_char  = k2;
      t.entry_adjust = adj;
      plan_table[t.entry_index]  = {k1, k2, adj};
      plan_loaded[t.entry_index] = 1'b1;
      pending_req.push_back(t);
      items_queued++;
   endtask

   task automatic push_lookup(input logic [CHAR_W-1:0] k1, input logic [CHAR_W-1:0] k2);
      kptl_req_type t;
      t.req_type     = REQ_LOOKUP;
      t.entry_index  = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
      t.first_char   = k1;
      t.second_char  = k2;
      t.entry_adjust = ADJ_W'($urandom_range(16'hFFFF));
      pending_req.push_back(t);
      items_queued++;
   endtask

   // Hold until every transaction is taken and every response is back
   task automatic wait_drained();
      while (pending_req.size() != 0 || req_valid || kern_rsp_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pair_count(input int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      kern_pair_count = COUNT_W'(value);
   endtask

   // Load slots 0..n-1 with pairs sorted by first then second char, in short groups
   task automatic load_sorted_table(input int unsigned n);
      int k1;
      int k2;
      int grp;
      int top;
      top = 65535 - 41 * int'(n);
      if (top < 0) top = 0;
      k1  = $urandom_range(top);
      k2  = $urandom_range(60000);
      grp = 0;
      for (int unsigned i = 0; i < n; i++) begin
         if (i > 0) begin
            if (grp >= 12 || $urandom_range(2) == 0) begin
               k1  += $urandom_range(40, 1);
               k2  = $urandom_range(60000);
               grp = 0;
            end else begin
               k2 += $urandom_range(300);
            end
         end
         push_write(i, CHAR_W'(k1), CHAR_W'(k2), ADJ_W'($urandom_range(16'hFFFF)));
         grp++;
      end
   endtask

   // Set the count, make sure every live slot is loaded, then mostly look up known pairs
   task automatic run_phase(input int unsigned count, input bit reload, input int lookups);
      int unsigned    n;
      int unsigned    r;
      kptl_entry_type e;
      wait_drained();
      set_pair_count(count);
      n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      for (int unsigned i = 0; i < n; i++)
         if (!plan_loaded[i]) reload = 1'b1;
      if (reload) load_sorted_table(n);
      repeat (lookups) begin
         // drop in a stray write now and then, which may unsort the table
         if ($urandom_range(99) < 5)
            push_write($urandom_range(TABLE_DEPTH - 1), CHAR_W'($urandom_range(16'hFFFF)),
                       CHAR_W'($urandom_range(16'hFFFF)), ADJ_W'($urandom_range(16'hFFFF)));
         r = $urandom_range(99);
         if (n == 0 || r >= 85) begin
            push_lookup(CHAR_W'($urandom_range(16'hFFFF)), CHAR_W'($urandom_range(16'hFFFF)));
         end else begin
            e = plan_table[$urandom_range(n - 1)];
            if (r < 60) push_lookup(e.key1, e.key2);
            else if (r < 75) push_lookup(e.key1, CHAR_W'($urandom_range(16'hFFFF)));
            else if (r < 80) push_lookup(e.key1 + 16'd1, e.key2);
            else push_lookup(e.key1 - 16'd1, e.key2);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         kern_table[i]  = '0;
         plan_table[i]  = '0;
         plan_loaded[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty table at the reset count
      push_lookup(16'h0000, 16'h0000);
      push_lookup(16'hFFFF, 16'hFFFF);
      push_write(0, 16'hFFFF, 16'hFFFF, 16'h7FFF);
      push_write(TABLE_DEPTH - 1, 16'h0000, 16'h0000, 16'h8000);
      push_lookup(16'hFFFF, 16'hFFFF);

      // Single entry: hit, second char miss, first char below
      wait_drained();
      set_pair_count(1);
      push_lookup(16'hFFFF, 16'hFFFF);
      push_lookup(16'hFFFF, 16'h0000);
      push_lookup(16'h0000, 16'hFFFF);
      push_write(0, 16'h0000, 16'h0000, 16'h8000);
      push_lookup(16'h0000, 16'h0000);
      push_lookup(16'h0000, 16'h0001);
      push_write(1, 16'h0000, 16'hFFFF, 16'h0001);

      // Two entries in one group, then an unsorted pair
      wait_drained();
      set_pair_count(2);
      push_lookup(16'h0000, 16'hFFFF);
      push_lookup(16'h0001, 16'h0000);
      push_lookup(16'h0000, 16'h0005);
      push_write(0, 16'h0005, 16'h0005, 16'h0003);
      push_write(1, 16'h0000, 16'h0000, 16'h0002);
      push_lookup(16'h0000, 16'h0000);
      push_lookup(16'h0005, 16'h0005);
      push_lookup(16'hFFFF, 16'hFFFF);

      // Small tables
      repeat (6) run_phase($urandom_range(48, 1), 1'b1, 30);

      // Full table with no idling on either side
      wait_drained();
      calm = 1'b1;
      run_phase(TABLE_DEPTH, 1'b1, 60);
      wait_drained();
      calm = 1'b0;

      // Counts past the table depth, and zero with a loaded table
      run_phase(2047, 1'b0, 40);
      run_phase($urandom_range(2046, TABLE_DEPTH + 1), 1'b0, 40);
      run_phase(0, 1'b0, 10);
      run_phase(1, 1'b0, 10);

      while (items_queued < ITEM_TARGET)
         run_phase($urandom_range(48, 1), $urandom_range(3) != 0, 30);

      wait_drained();
      repeat (40) @(posedge clock);
      if (kern_rsp_expected.size() != 0) begin
         $error("%0d expected responses never arrived", kern_rsp_expected.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("kern_pair_table_lookup regression: pass");
      end else begin
         $display("kern_pair_table_lookup regression: fail");
      end
      $finish;
   end

endmodule
